// ----- rtl/move_to_back_dedup_queue_unit_defines.svh -----
// Assertion macros for the move-to-back dedup queue unit
`ifndef MOVE_TO_BACK_DEDUP_QUEUE_UNIT_DEFINES_SVH
`define MOVE_TO_BACK_DEDUP_QUEUE_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its trigger
`define MTBQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define MTBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mtbq_pkg.sv -----
// Shared widths, status codes and action codes of the move-to-back dedup queue
`timescale 1ns / 1ps
package mtbq_pkg;

  localparam int VALUE_W = 32;
  localparam int OCC_W   = 5;
  localparam int STAT_W  = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY_DEQ = 2'd1,
    ST_FULL_DROP = 2'd2,
    ST_MOVED     = 2'd3
  } status_t;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_t;

endpackage

// ----- rtl/mtbq_if.sv -----
// Request and response channel interfaces of the move-to-back dedup queue
`timescale 1ns / 1ps
interface mtbq_in_if
  import mtbq_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               action;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface mtbq_out_if
  import mtbq_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] head_value;
  logic               is_empty;
  logic [OCC_W-1:0]   occupancy;
  logic [STAT_W-1:0]  status;

  modport source (output valid, output head_value, output is_empty, output occupancy,
                  output status, input ready);
  modport sink   (input valid, input head_value, input is_empty, input occupancy,
                  input status, output ready);
endinterface

// ----- rtl/move_to_back_dedup_queue_unit.sv -----
// Move-to-back dedup queue: circular entry store walked by one shared comparator.
// A dequeue advances the head, then reads the new head word unless the queue ends empty. An enqueue
//   compares stored entries in order, moves later entries down after a match, appends the word
//   (not on a full drop), then reads the head; each entry is read through the registered read port.
// Throughput: one word at a time; the next is taken the cycle after the response is taken.
// Reset (synchronous, active low) empties the queue; stored words are not cleared.
`timescale 1ns / 1ps
`include "move_to_back_dedup_queue_unit_defines.svh"
module move_to_back_dedup_queue_unit
  import mtbq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input logic          clk,
  input logic          rst_n,
  mtbq_in_if.sink      in_ch,
  mtbq_out_if.source   out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SH_RD,
    S_SH_WR,
    S_APPEND,
    S_HEAD_RD,
    S_HEAD_CAP,
    S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [ELEM_WIDTH-1:0] val_r, val_nxt;
  logic [ELEM_WIDTH-1:0] head_val_r, head_val_nxt;
  status_t               status_r, status_nxt;

  logic [AW-1:0]         rd_addr;
  logic [ELEM_WIDTH-1:0] rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [ELEM_WIDTH-1:0] wr_data;
  logic [CW-1:0]         idx_inc;

  // map a position counted from the head onto a store address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] pos);
    logic [AW:0] sum;
    sum = (AW + 1)'(head) + (AW + 1)'(pos[AW-1:0]);
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  mtbq_mem #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign idx_inc = idx_r + ONE_C;

  // sequence one word: a dequeue, or an enqueue's search, compact and append; then fetch the head
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    val_nxt      = val_r;
    head_val_nxt = head_val_r;
    status_nxt   = status_r;
    rd_addr      = head_r;
    wr_en        = 1'b0;
    wr_addr      = phys(head_r, cnt_r);
    wr_data      = val_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          val_nxt    = ELEM_WIDTH'(in_ch.value);
          idx_nxt    = '0;
          status_nxt = ST_OK;
          if (in_ch.action == ACT_DEQ) begin
            if (cnt_r == '0) begin
              status_nxt   = ST_EMPTY_DEQ;
              head_val_nxt = '0;
              state_nxt    = S_RESP;
            end else begin
              head_nxt = phys(head_r, ONE_C);
              cnt_nxt  = cnt_r - ONE_C;
              if (cnt_r == ONE_C) begin
                head_val_nxt = '0;
                state_nxt    = S_RESP;
              end else begin
                state_nxt = S_HEAD_RD;
              end
            end
          end else if (cnt_r == '0) begin
            state_nxt = S_APPEND;
          end else begin
            state_nxt = S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD: begin
        rd_addr   = phys(head_r, idx_r);
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (rd_data == val_r) begin
          // unlink the match, then close the gap behind it
          status_nxt = ST_MOVED;
          cnt_nxt    = cnt_r - ONE_C;
          state_nxt  = (idx_inc < cnt_r) ? S_SH_RD : S_APPEND;
        end else if (idx_inc == cnt_r) begin
          if (cnt_r == DEPTH_C) begin
            status_nxt = ST_FULL_DROP;
            state_nxt  = S_HEAD_RD;
          end else begin
            state_nxt = S_APPEND;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SRCH_RD;
        end
      end
      S_SH_RD: begin
        rd_addr   = phys(head_r, idx_inc);
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        wr_en     = 1'b1;
        wr_addr   = phys(head_r, idx_r);
        wr_data   = rd_data;
        idx_nxt   = idx_inc;
        state_nxt = (idx_inc < cnt_r) ? S_SH_RD : S_APPEND;
      end
      S_APPEND: begin
        wr_en     = 1'b1;
        cnt_nxt   = cnt_r + ONE_C;
        state_nxt = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        rd_addr   = head_r;
        state_nxt = S_HEAD_CAP;
      end
      S_HEAD_CAP: begin
        head_val_nxt = rd_data;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold state and the response word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      cnt_r      <= cnt_nxt;
      idx_r      <= idx_nxt;
      val_r      <= val_nxt;
      head_val_r <= head_val_nxt;
      status_r   <= status_nxt;
    end
  end

  // drive the channels
  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = (state_r == S_RESP);
  assign out_ch.head_value = VALUE_W'(head_val_r);
  assign out_ch.is_empty   = (cnt_r == '0);
  assign out_ch.occupancy  = OCC_W'(cnt_r);
  assign out_ch.status     = status_r;

  `MTBQ_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= DEPTH_C, "occupancy above depth")
  `MTBQ_ASSERT_SAME(a_busy_while_resp, clk, rst_n,
                    out_ch.valid, !in_ch.ready, "word taken during response")
  `MTBQ_ASSERT_NEXT(a_idle_after_resp, clk, rst_n,
                    out_ch.valid && out_ch.ready, in_ch.ready, "not idle after response")
  `MTBQ_ASSERT_SAME(a_moved_not_empty, clk, rst_n,
                    out_ch.valid && (status_r == ST_MOVED), !out_ch.is_empty,
                    "moved word left queue empty")

endmodule

// ----- rtl/mtbq_mem.sv -----
// Entry storage: one write port, one registered read port
`timescale 1ns / 1ps
module mtbq_mem #(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [ELEM_WIDTH-1:0]    rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [ELEM_WIDTH-1:0]    wr_data
);

  logic [ELEM_WIDTH-1:0] mem [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_data_r;

  // write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // register the read word
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
